// ===== sv/yc48_pkg.sv =====
// Shared types, constants and pixel mapping functions for the YUY2 to YC48 upsampler.
// Used by yc48_hold, yc48_convert and yuy2_to_yc48_upsampler; depends on nothing.
package yc48_pkg;

  // Luma scale and bias, chroma scale
  localparam int LUMA_COEF   = 4788;
  localparam int LUMA_HALF   = LUMA_COEF / 2;
  localparam int LUMA_BIAS   = LUMA_COEF / 2 - 299;
  localparam int CHROMA_COEF = 4682;
  localparam int CHROMA_HALF = CHROMA_COEF / 2;
  // Rounding term of the chroma product after the 8-bit input shift is folded in
  localparam int CHROMA_RND  = 128;

  localparam int Y_W = 14;
  localparam int C_W = 13;

  // One YUY2 macropixel
  typedef struct packed {
    logic [7:0] luma_even;
    logic [7:0] chroma_u;
    logic [7:0] luma_odd;
    logic [7:0] chroma_v;
  } macropixel_t;

  // One pixel pair to convert: macropixel, successor chroma, row-end mark
  typedef struct packed {
    macropixel_t mp;
    logic [7:0]  next_u;
    logic [7:0]  next_v;
    logic        last;
  } pair_job_t;

  // floor(((y<<8)-32768)*4788 / 65536) + 2095
  function automatic logic signed [Y_W-1:0] luma_map(input logic [7:0] y);
    logic [20:0]    p;
    logic [Y_W-1:0] r;
    p = 21'(y) * 21'(LUMA_COEF);
    r = {1'b0, p[20:8]} - Y_W'(LUMA_HALF) + Y_W'(LUMA_BIAS);
    return $signed(r);
  endfunction

  // floor((((c<<8)-32768)*4682 + 32768) / 65536)
  function automatic logic signed [C_W-1:0] chroma_map(input logic [7:0] c);
    logic [20:0]    p;
    logic [C_W-1:0] r;
    p = 21'(c) * 21'(CHROMA_COEF) + 21'(CHROMA_RND);
    r = p[20:8] - C_W'(CHROMA_HALF);
    return $signed(r);
  endfunction

  // Rounded-up mean of two chroma samples
  function automatic logic [7:0] chroma_mean(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = 9'(a) + 9'(b) + 9'd1;
    return s[8:1];
  endfunction

endpackage

// ===== sv/yc48_hold.sv =====
// Macropixel hold stage: keeps one macropixel until its successor's chroma arrives
// and issues pixel-pair jobs into a job register. Depends on yc48_pkg.
module yc48_hold import yc48_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  luma_even,
  input  logic [7:0]  chroma_u,
  input  logic [7:0]  luma_odd,
  input  logic [7:0]  chroma_v,
  input  logic        row_end,
  output logic        job_valid,
  input  logic        job_stall,
  output pair_job_t   job
);

  macropixel_t held_mp, held_mp_next;
  logic        held_valid, held_valid_next;
  macropixel_t flush_mp, flush_mp_next;
  logic        flush_pending, flush_pending_next;
  pair_job_t   job_next;
  logic        job_valid_next;
  logic        job_free;
  logic        accept;
  macropixel_t cur;

  // Stall input while a row-end flush waits or the job register stays full
  always_comb begin
    job_free = !job_valid || !job_stall;
    in_stall = flush_pending || !job_free;
    accept   = in_valid && !in_stall;
    cur      = '{luma_even: luma_even, chroma_u: chroma_u,
                 luma_odd: luma_odd, chroma_v: chroma_v};
  end

  // Issue jobs, update the held macropixel
  always_comb begin
    held_mp_next       = held_mp;
    held_valid_next    = held_valid;
    flush_mp_next      = flush_mp;
    flush_pending_next = flush_pending;
    job_next           = job;
    job_valid_next     = job_valid && job_stall;
    if (flush_pending && job_free) begin
      job_next           = '{mp: flush_mp, next_u: flush_mp.chroma_u,
                             next_v: flush_mp.chroma_v, last: 1'b1};
      job_valid_next     = 1'b1;
      flush_pending_next = 1'b0;
    end else if (accept) begin
      if (held_valid) begin
        job_next       = '{mp: held_mp, next_u: chroma_u, next_v: chroma_v, last: 1'b0};
        job_valid_next = 1'b1;
        if (row_end) begin
          flush_mp_next      = cur;
          flush_pending_next = 1'b1;
          held_valid_next    = 1'b0;
        end else begin
          held_mp_next = cur;
        end
      end else if (row_end) begin
        job_next       = '{mp: cur, next_u: chroma_u, next_v: chroma_v, last: 1'b1};
        job_valid_next = 1'b1;
      end else begin
        held_mp_next    = cur;
        held_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      flush_pending <= 1'b0;
      job_valid     <= 1'b0;
    end else begin
      held_valid    <= held_valid_next;
      flush_pending <= flush_pending_next;
      job_valid     <= job_valid_next;
    end
    held_mp  <= held_mp_next;
    flush_mp <= flush_mp_next;
    job      <= job_next;
  end

  a_flush_stalls: assert property (@(posedge clk) disable iff (rst)
    flush_pending |-> in_stall)
    else $error("input taken while a row-end flush is pending");

  a_flush_not_held: assert property (@(posedge clk) disable iff (rst)
    !(flush_pending && held_valid))
    else $error("macropixel held while a row-end flush is pending");

  a_row_end_drops_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && row_end) |=> !held_valid)
    else $error("macropixel still held after a row-end transfer");

endmodule

// ===== sv/yc48_convert.sv =====
// Conversion stage: maps one pixel-pair job to YC48 values in the result register.
// Depends on yc48_pkg.
module yc48_convert import yc48_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_stall,
  input  pair_job_t             job,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Y_W-1:0] out_y_even,
  output logic signed [C_W-1:0] out_cb_even,
  output logic signed [C_W-1:0] out_cr_even,
  output logic signed [Y_W-1:0] out_y_odd,
  output logic signed [C_W-1:0] out_cb_odd,
  output logic signed [C_W-1:0] out_cr_odd,
  output logic                  out_last
);

  logic take;
  logic [7:0] ui, vi;

  // Load the result register whenever it is empty or being drained
  always_comb begin
    take      = !out_valid || !out_stall;
    job_stall = !take;
    ui        = chroma_mean(job.mp.chroma_u, job.next_u);
    vi        = chroma_mean(job.mp.chroma_v, job.next_v);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= job_valid;
    end
    if (take && job_valid) begin
      out_y_even  <= luma_map(job.mp.luma_even);
      out_cb_even <= chroma_map(job.mp.chroma_u);
      out_cr_even <= chroma_map(job.mp.chroma_v);
      out_y_odd   <= luma_map(job.mp.luma_odd);
      out_cb_odd  <= chroma_map(ui);
      out_cr_odd  <= chroma_map(vi);
      out_last    <= job.last;
    end
  end

  a_job_lands: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_stall) |=> out_valid)
    else $error("job transfer did not fill the result register");

endmodule

// ===== sv/yuy2_to_yc48_upsampler.sv =====
// Top level of the YUY2 to YC48 upsampler: hold stage followed by conversion stage.
// Depends on yc48_pkg, yc48_hold and yc48_convert.
//
// Takes one YUY2 macropixel per transfer and returns pixel pairs in YC48 scale, one
// macropixel late: a macropixel is held until the next one supplies the chroma for
// its odd pixel. The first macropixel of a row returns nothing unless it is also the
// row end; each later one returns the pair of the one before it; the row-end
// macropixel also returns its own pair, with its chroma repeated and out_last set.
// One macropixel is accepted per clock while the output does not stall, except that
// a row end arriving behind a held macropixel yields two pairs and holds off input
// while the second pair enters the job register. A pair passes through the job
// register, then the result register, on its way to the output; the row-end
// macropixel's own pair follows directly behind the pair before it.
module yuy2_to_yc48_upsampler import yc48_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            luma_even,
  input  logic [7:0]            chroma_u,
  input  logic [7:0]            luma_odd,
  input  logic [7:0]            chroma_v,
  input  logic                  row_end,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Y_W-1:0] out_y_even,
  output logic signed [C_W-1:0] out_cb_even,
  output logic signed [C_W-1:0] out_cr_even,
  output logic signed [Y_W-1:0] out_y_odd,
  output logic signed [C_W-1:0] out_cb_odd,
  output logic signed [C_W-1:0] out_cr_odd,
  output logic                  out_last
);

  logic      job_valid;
  logic      job_stall;
  pair_job_t job;

  yc48_hold u_hold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .luma_even (luma_even),
    .chroma_u  (chroma_u),
    .luma_odd  (luma_odd),
    .chroma_v  (chroma_v),
    .row_end   (row_end),
    .job_valid (job_valid),
    .job_stall (job_stall),
    .job       (job)
  );

  yc48_convert u_convert (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job_stall   (job_stall),
    .job         (job),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_y_even  (out_y_even),
    .out_cb_even (out_cb_even),
    .out_cr_even (out_cr_even),
    .out_y_odd   (out_y_odd),
    .out_cb_odd  (out_cb_odd),
    .out_cr_odd  (out_cr_odd),
    .out_last    (out_last)
  );

endmodule
